FILE: rtl/core/sgoc_pkg.sv
// Shared types and constants for the segment grid overlap counter.
// No dependencies; sgoc_walker and the top level refer to it by scoped names.
package sgoc_pkg;

	localparam int COORD_BITS = 10;
	localparam int CELL_BITS  = 2 * COORD_BITS;
	localparam int CELL_COUNT = 1 << CELL_BITS;
	localparam int HIT_BITS   = 2;
	localparam int TOTAL_BITS = 21;

	localparam logic [HIT_BITS-1:0] HIT_ZERO = '0;
	localparam logic [HIT_BITS-1:0] HIT_TWO  = HIT_BITS'(2);
	localparam logic [HIT_BITS-1:0] HIT_SAT  = '1;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [CELL_BITS-1:0]  cell_addr_t;
	typedef logic [HIT_BITS-1:0]   hit_t;
	typedef logic [TOTAL_BITS-1:0] total_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} walk_state_t;

	// cell command from the sequencer to the grid update stage
	typedef struct packed {
		logic       rd;
		logic       clr;
		cell_addr_t addr;
	} cell_cmd_t;

endpackage

FILE: rtl/core/sgoc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the cell hit grid.
module sgoc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/sgoc_walker.sv
// Segment sequencer: classifies a segment, then steps one cell per cycle.
// Also runs the grid clearing pass after reset. Uses sgoc_pkg.
module sgoc_walker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                diag_en,
	input  sgoc_pkg::coord_t    x_start,
	input  sgoc_pkg::coord_t    y_start,
	input  sgoc_pkg::coord_t    x_end,
	input  sgoc_pkg::coord_t    y_end,
	output logic                busy,
	output logic                done,
	output logic                skip,
	output sgoc_pkg::cell_cmd_t cmd
);

	sgoc_pkg::walk_state_t state_q, state_nx;

	sgoc_pkg::coord_t     x_q, y_q, rem_q;
	logic                 xneg_q, yneg_q, xmove_q, ymove_q, skip_q;
	sgoc_pkg::cell_addr_t clr_q;

	sgoc_pkg::coord_t dx, dy, len_m1;
	logic             accept, is_skip;

	assign accept = start && (state_q == sgoc_pkg::ST_IDLE);

	// segment classification
	always_comb begin
		dx      = (x_end >= x_start) ? x_end - x_start : x_start - x_end;
		dy      = (y_end >= y_start) ? y_end - y_start : y_start - y_end;
		len_m1  = (dx > dy) ? dx : dy;
		is_skip = (dx != '0) && (dy != '0) && (!diag_en || (dx != dy));
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			sgoc_pkg::ST_CLEAR: begin
				if (&clr_q) state_nx = sgoc_pkg::ST_IDLE;
			end
			sgoc_pkg::ST_IDLE: begin
				if (accept) state_nx = is_skip ? sgoc_pkg::ST_DONE : sgoc_pkg::ST_WALK;
			end
			sgoc_pkg::ST_WALK: begin
				if (rem_q == '0) state_nx = sgoc_pkg::ST_DRAIN;
			end
			sgoc_pkg::ST_DRAIN: state_nx = sgoc_pkg::ST_DONE;
			sgoc_pkg::ST_DONE:  state_nx = sgoc_pkg::ST_IDLE;
			default:            state_nx = sgoc_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy     = 1'b1;
		done     = 1'b0;
		cmd.rd   = 1'b0;
		cmd.clr  = 1'b0;
		cmd.addr = {y_q, x_q};
		unique case (state_q)
			sgoc_pkg::ST_CLEAR: begin
				cmd.clr  = 1'b1;
				cmd.addr = clr_q;
			end
			sgoc_pkg::ST_IDLE:  busy   = 1'b0;
			sgoc_pkg::ST_WALK:  cmd.rd = 1'b1;
			sgoc_pkg::ST_DRAIN: ;
			sgoc_pkg::ST_DONE:  done   = 1'b1;
			default:            ;
		endcase
	end

	assign skip = skip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgoc_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == sgoc_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	// segment registers: loaded on accept, stepped while walking
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= x_start;
			y_q     <= y_start;
			xneg_q  <= x_end < x_start;
			yneg_q  <= y_end < y_start;
			xmove_q <= dx != '0;
			ymove_q <= dy != '0;
			rem_q   <= len_m1;
			skip_q  <= is_skip;
		end else if (state_q == sgoc_pkg::ST_WALK) begin
			if (xmove_q) x_q <= xneg_q ? x_q - 1'b1 : x_q + 1'b1;
			if (ymove_q) y_q <= yneg_q ? y_q - 1'b1 : y_q + 1'b1;
			rem_q <= rem_q - 1'b1;
		end
	end

endmodule

FILE: rtl/core/segment_grid_overlap_counter.sv
// Top level of the segment grid overlap counter.
// Depends on sgoc_pkg, sgoc_ram and sgoc_walker.
//
// One segment word is taken when start is high and busy is low. After reset
// the block first clears all 2^20 (2^(2*COORD_BITS)) cells of the hit grid,
// one cell per cycle; busy stays high for that whole pass, configuration
// writes are taken all the same. A drawn segment of L cells (L is the larger
// of the column and row spans plus one) is walked cell by cell, then a
// drain state finishes the last write-back, then done is raised for one
// cycle; the block takes the next word only after that, back in idle. The
// single grid RAM does one cell read-modify-write per cycle. A segment that
// is skipped raises done in the cycle after it is taken. The result
// (overlap_cells, segment_skipped) is valid only in the done cycle; there
// is no back-pressure, so capture it then. diagonal_enable is to be
// written through cfg_valid/cfg_ready/cfg_data only while the block is
// idle, by the user; the block itself does not enforce it.
module segment_grid_overlap_counter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  logic [sgoc_pkg::COORD_BITS-1:0] x_start,
	input  logic [sgoc_pkg::COORD_BITS-1:0] y_start,
	input  logic [sgoc_pkg::COORD_BITS-1:0] x_end,
	input  logic [sgoc_pkg::COORD_BITS-1:0] y_end,
	output logic                         done,
	output logic [sgoc_pkg::TOTAL_BITS-1:0] overlap_cells,
	output logic                         segment_skipped
);

	logic                 diag_en_q;
	sgoc_pkg::cell_cmd_t  cmd;
	logic                 skip;

	// read-modify-write stage: read issued in the walk cycle, written back here
	logic                 pend_s1;
	sgoc_pkg::cell_addr_t addr_s1;
	sgoc_pkg::hit_t       hit_rd, hit_new;
	sgoc_pkg::total_t     total_q;

	logic                 ram_we;
	sgoc_pkg::cell_addr_t ram_waddr;
	sgoc_pkg::hit_t       ram_wdata;
	logic                 bump;

	// config register: always ready, one-bit word
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diag_en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			diag_en_q <= cfg_data;
		end
	end

	sgoc_walker u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.diag_en (diag_en_q),
		.x_start (x_start),
		.y_start (y_start),
		.x_end   (x_end),
		.y_end   (y_end),
		.busy    (busy),
		.done    (done),
		.skip    (skip),
		.cmd     (cmd)
	);

	// saturating hit counter; a cell reaching two counts as a new overlap
	always_comb begin
		hit_new = (hit_rd == sgoc_pkg::HIT_SAT) ? hit_rd : hit_rd + 1'b1;
		bump    = pend_s1 && (hit_rd != sgoc_pkg::HIT_SAT) &&
		          (hit_new == sgoc_pkg::HIT_TWO);
	end

	// clearing pass and write-back never overlap
	always_comb begin
		ram_we    = cmd.clr || pend_s1;
		ram_waddr = cmd.clr ? cmd.addr : addr_s1;
		ram_wdata = cmd.clr ? sgoc_pkg::HIT_ZERO : hit_new;
	end

	sgoc_ram #(
		.WIDTH (sgoc_pkg::HIT_BITS),
		.DEPTH (sgoc_pkg::CELL_COUNT)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd),
		.raddr (cmd.addr),
		.rdata (hit_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			total_q <= '0;
		end else begin
			pend_s1 <= cmd.rd;
			if (bump && !(&total_q)) total_q <= total_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cmd.addr;
	end

	assign overlap_cells   = total_q;
	assign segment_skipped = skip;

	// assertions
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_no_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr && pend_s1))
		else $error("write-back during clearing pass");

	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (total_q >= $past(total_q)))
		else $error("overlap total decreased");

	a_done_settled: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !pend_s1)
		else $error("result shown before last write-back");

endmodule

FILE: dv/testbench.sv
// Self-checking bench for segment_grid_overlap_counter: directed segments, then random phases.
// Needs sgoc_pkg and the RTL under rtl/core; the grid predictor lives in this file.
module testbench;

	// longest busy stretch for one word: full-length segment plus pipeline
	localparam int WORD_CYCLES_MAX = (1 << sgoc_pkg::COORD_BITS) + 3;
	// clearing pass after reset dominates; leave generous margin on top of it
	localparam int STALL_LIMIT = 3 * sgoc_pkg::CELL_COUNT + 16 * WORD_CYCLES_MAX;
	localparam int COORD_MAX = (1 << sgoc_pkg::COORD_BITS) - 1;
	localparam int REPORT_MAX = 10;

	typedef enum logic [1:0] {
		PLAN_SEGMENT,
		PLAN_CONFIG,
		PLAN_SETTLE
	} plan_kind_t;

	typedef struct {
		plan_kind_t       kind;
		sgoc_pkg::coord_t xa;
		sgoc_pkg::coord_t ya;
		sgoc_pkg::coord_t xb;
		sgoc_pkg::coord_t yb;
		logic             diag;
		int               gap;
	} plan_word_t;

	typedef struct {
		sgoc_pkg::total_t cells;
		logic             skipped;
		sgoc_pkg::coord_t xa;
		sgoc_pkg::coord_t ya;
		sgoc_pkg::coord_t xb;
		sgoc_pkg::coord_t yb;
	} overlap_answer_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic             cfg_data = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	sgoc_pkg::coord_t x_start = '0;
	sgoc_pkg::coord_t y_start = '0;
	sgoc_pkg::coord_t x_end = '0;
	sgoc_pkg::coord_t y_end = '0;
	logic             done;
	sgoc_pkg::total_t overlap_cells;
	logic             segment_skipped;

	segment_grid_overlap_counter DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.start           (start),
		.busy            (busy),
		.x_start         (x_start),
		.y_start         (y_start),
		.x_end           (x_end),
		.y_end           (y_end),
		.done            (done),
		.overlap_cells   (overlap_cells),
		.segment_skipped (segment_skipped)
	);

	always #5 clk = ~clk;

	// shadow of the block: hit counters, running overlap count, diagonal mode
	bit [sgoc_pkg::HIT_BITS-1:0]   hit_grid [sgoc_pkg::CELL_COUNT];
	bit [sgoc_pkg::TOTAL_BITS-1:0] overlap_count;
	bit                            diag_mode;

	plan_word_t      segment_plan[$];
	overlap_answer_t overlap_answers[$];

	// handshake flags: set by the sampler at posedge, read by the driver at negedge
	bit seg_taken;
	bit cfg_taken;

	int errors;
	int segments_taken;
	int skipped_seen;
	int diag_drawn;
	int cfg_writes;
	int idle_left;
	int held_gap;
	int stall_cycles;

	// Rasterize one segment into the shadow grid; returns 1 when it is skipped.
	// Counters saturate at three, the total at all ones.
	function automatic logic draw_segment(input sgoc_pkg::coord_t xa,
			input sgoc_pkg::coord_t ya, input sgoc_pkg::coord_t xb,
			input sgoc_pkg::coord_t yb);
		int dx, dy, steps, cx, cy, idx, i;
		dx = (xb >= xa) ? int'(xb) - int'(xa) : int'(xa) - int'(xb);
		dy = (yb >= ya) ? int'(yb) - int'(ya) : int'(ya) - int'(yb);
		if (dx != 0 && dy != 0 && (!diag_mode || dx != dy))
			return 1'b1;
		steps = (dx > dy) ? dx : dy;
		cx = xa;
		cy = ya;
		for (i = 0; i <= steps; i++) begin
			idx = (cy << sgoc_pkg::COORD_BITS) | cx;
			if (hit_grid[idx] != sgoc_pkg::HIT_SAT) begin
				hit_grid[idx] = hit_grid[idx] + 1'b1;
				if (hit_grid[idx] == sgoc_pkg::HIT_TWO && overlap_count != '1)
					overlap_count++;
			end
			if (dx != 0)
				cx += (xb < xa) ? -1 : 1;
			if (dy != 0)
				cy += (yb < ya) ? -1 : 1;
		end
		return 1'b0;
	endfunction

	function automatic int pick_gap(input int mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			0: return 0;
			1: begin
				if (r < 55) return 0;
				if (r < 85) return $urandom_range(1, 4);
				if (r < 97) return $urandom_range(5, 40);
				return $urandom_range(60, 150);
			end
			default: begin
				if (r < 30) return 0;
				if (r < 70) return $urandom_range(1, 10);
				if (r < 92) return $urandom_range(11, 60);
				return $urandom_range(80, 300);
			end
		endcase
	endfunction

	task automatic plan_segment(input int xa, input int ya, input int xb, input int yb,
			input int gap);
		plan_word_t w;
		w.kind = PLAN_SEGMENT;
		w.xa = sgoc_pkg::coord_t'(xa);
		w.ya = sgoc_pkg::coord_t'(ya);
		w.xb = sgoc_pkg::coord_t'(xb);
		w.yb = sgoc_pkg::coord_t'(yb);
		w.diag = 1'b0;
		w.gap = gap;
		segment_plan.push_back(w);
	endtask

	// pause until all answers are in; every register write is preceded by one
	task automatic plan_settle();
		plan_word_t w;
		w.kind = PLAN_SETTLE;
		w.gap = 0;
		segment_plan.push_back(w);
	endtask

	task automatic plan_config(input logic value);
		plan_word_t w;
		w.kind = PLAN_CONFIG;
		w.diag = value;
		w.gap = 0;
		plan_settle();
		segment_plan.push_back(w);
	endtask

	// Mostly short axis-aligned and 45-degree segments clustered near a hotspot so
	// they pile up; a few long ones, a few anywhere, some slanted or fully random.
	task automatic plan_random_segment(input int hot_x, input int hot_y, input int gap_mode);
		int shape, span, base_x, base_y, lo_x, lo_y, xa, ya, xb, yb, t;
		shape = $urandom_range(0, 99);
		span = ($urandom_range(0, 99) < 4) ? $urandom_range(100, COORD_MAX)
			: $urandom_range(0, 24);
		if ($urandom_range(0, 99) < 80) begin
			base_x = hot_x;
			base_y = hot_y;
		end else begin
			base_x = $urandom_range(0, COORD_MAX - 40);
			base_y = $urandom_range(0, COORD_MAX - 40);
		end
		lo_x = base_x + $urandom_range(0, 40);
		lo_y = base_y + $urandom_range(0, 40);
		if (lo_x > COORD_MAX - span) lo_x = COORD_MAX - span;
		if (lo_y > COORD_MAX - span) lo_y = COORD_MAX - span;
		xa = lo_x;
		ya = lo_y;
		xb = lo_x;
		yb = lo_y;
		if (shape < 12) begin
			xa = $urandom_range(0, COORD_MAX);
			ya = $urandom_range(0, COORD_MAX);
			xb = $urandom_range(0, COORD_MAX);
			yb = $urandom_range(0, COORD_MAX);
		end else if (shape < 46) begin
			xb = lo_x + span;
		end else if (shape < 80) begin
			yb = lo_y + span;
		end else if (shape < 95) begin
			xb = lo_x + span;
			yb = lo_y + span;
		end else begin
			xb = lo_x + span;
			yb = lo_y + $urandom_range(0, span);
		end
		// random direction on each axis gives all four diagonal orientations
		if ($urandom_range(0, 1)) begin
			t = xa; xa = xb; xb = t;
		end
		if ($urandom_range(0, 1)) begin
			t = ya; ya = yb; yb = t;
		end
		plan_segment(xa, ya, xb, yb, pick_gap(gap_mode));
	endtask

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= REPORT_MAX)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// Sampler: register writes, accepted words (predicted here) and results.
	always @(posedge clk) begin
		overlap_answer_t a;
		overlap_answer_t want;
		seg_taken = 1'b0;
		cfg_taken = 1'b0;
		if (arst_n) begin
			if (done) begin
				if (overlap_answers.size() == 0) begin
					report_mismatch($sformatf("result with none pending: cells=%0d skipped=%0b",
						overlap_cells, segment_skipped));
				end else begin
					want = overlap_answers.pop_front();
					if (overlap_cells !== want.cells)
						report_mismatch($sformatf(
							"overlap_cells seg (%0d,%0d)-(%0d,%0d): want %0d got %0d",
							want.xa, want.ya, want.xb, want.yb, want.cells, overlap_cells));
					if (segment_skipped !== want.skipped)
						report_mismatch($sformatf(
							"segment_skipped seg (%0d,%0d)-(%0d,%0d): want %0b got %0b",
							want.xa, want.ya, want.xb, want.yb, want.skipped, segment_skipped));
				end
			end
			if (cfg_valid && cfg_ready) begin
				diag_mode = cfg_data;
				cfg_taken = 1'b1;
				cfg_writes++;
			end
			if (start && !busy) begin
				a.xa = x_start;
				a.ya = y_start;
				a.xb = x_end;
				a.yb = y_end;
				a.skipped = draw_segment(x_start, y_start, x_end, y_end);
				a.cells = overlap_count;
				overlap_answers.push_back(a);
				seg_taken = 1'b1;
				segments_taken++;
				if (a.skipped)
					skipped_seen++;
				else if (x_start != x_end && y_start != y_end)
					diag_drawn++;
			end
		end
	end

	// Driver: one word from the plan at a time, all changes at negedge.
	// Next values are worked out first so each output gets a single NBA.
	always @(negedge clk) begin
		plan_word_t w;
		logic nxt_start;
		logic nxt_cfg_valid;
		nxt_start = start;
		nxt_cfg_valid = cfg_valid;
		if (arst_n) begin
			if (start && seg_taken) begin
				nxt_start = 1'b0;
				idle_left = held_gap;
			end
			if (cfg_valid && cfg_taken)
				nxt_cfg_valid = 1'b0;
			if (!nxt_start && !nxt_cfg_valid && segment_plan.size() != 0) begin
				if (idle_left > 0) begin
					idle_left--;
				end else begin
					w = segment_plan[0];
					case (w.kind)
						PLAN_SEGMENT: begin
							void'(segment_plan.pop_front());
							x_start <= w.xa;
							y_start <= w.ya;
							x_end <= w.xb;
							y_end <= w.yb;
							held_gap = w.gap;
							nxt_start = 1'b1;
						end
						PLAN_CONFIG: begin
							// register only changes with the block idle
							if (overlap_answers.size() == 0 && !busy) begin
								void'(segment_plan.pop_front());
								cfg_data <= w.diag;
								nxt_cfg_valid = 1'b1;
							end
						end
						PLAN_SETTLE: begin
							if (overlap_answers.size() == 0)
								void'(segment_plan.pop_front());
						end
						default: void'(segment_plan.pop_front());
					endcase
				end
			end
		end
		start <= nxt_start;
		cfg_valid <= nxt_cfg_valid;
	end

	// Watchdog: any accepted word, write or result restarts the count.
	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || done)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: %0d cycles with no progress", stall_cycles);
			$display("segment_grid_overlap_counter test failed");
			$finish;
		end
	end

	initial begin
		int phase, k, hot_x, hot_y, gap_mode;

		// Directed, diagonals off. Single point twice, two full rows and a full
		// column through the corners, a reversed column, the corner cell driven to
		// three, a disabled 45-degree diagonal, a slanted one, and
		// alternating-bit coordinates.
		plan_config(1'b0);
		plan_segment(0, 0, 0, 0, 0);
		plan_segment(0, 0, 0, 0, 1);
		plan_segment(0, 0, COORD_MAX, 0, 0);
		plan_segment(COORD_MAX, COORD_MAX, 0, COORD_MAX, 3);
		plan_segment(COORD_MAX, 0, COORD_MAX, COORD_MAX, 0);
		plan_segment(5, 20, 5, 0, 0);
		plan_segment(0, 0, 10, 10, 0);
		plan_segment(0, 0, 3, 7, 2);
		plan_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
		plan_segment(682, 341, 341, 682, 0);

		// Directed, diagonals on: all four orientations, a slanted one that
		// must still be dropped, and repeat hits on saturated cells.
		plan_config(1'b1);
		plan_segment(0, 0, COORD_MAX, COORD_MAX, 0);
		plan_segment(COORD_MAX, 0, 0, COORD_MAX, 0);
		plan_segment(20, 10, 10, 0, 1);
		plan_segment(10, 20, 20, 10, 0);
		plan_segment(0, 0, 5, 4, 0);
		plan_segment(341, 682, 682, 341, 0);
		plan_segment(512, 512, 512, 512, 0);
		plan_segment(0, 0, 0, 0, 0);

		// Random phases alternate the diagonal mode; gap style rotates between
		// back-to-back, mixed and sparse. A mid-phase drain adds pressure.
		for (phase = 0; phase < 8; phase++) begin
			plan_config(phase[0] ? 1'b0 : 1'b1);
			gap_mode = phase % 3;
			hot_x = $urandom_range(0, COORD_MAX - 40);
			hot_y = $urandom_range(0, COORD_MAX - 40);
			for (k = 0; k < 70; k++) begin
				if (k == 35)
					plan_settle();
				plan_random_segment(hot_x, hot_y, gap_mode);
			end
		end

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		while (segment_plan.size() != 0 || start || cfg_valid || overlap_answers.size() != 0)
			@(posedge clk);
		// catch any stray result after the last expected one
		repeat (2 * WORD_CYCLES_MAX) @(posedge clk);

		$display("covered %0d segments: %0d drawn (%0d diagonal), %0d skipped",
			segments_taken, segments_taken - skipped_seen, diag_drawn, skipped_seen);
		$display("%0d diagonal-mode writes, final overlap count %0d, %0d mismatches",
			cfg_writes, overlap_count, errors);
		if (errors == 0)
			$display("segment_grid_overlap_counter test passed");
		else
			$display("segment_grid_overlap_counter test failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/sgoc_pkg.sv
rtl/core/sgoc_ram.sv
rtl/core/sgoc_walker.sv
rtl/core/segment_grid_overlap_counter.sv
dv/testbench.sv
